// ===== rtl/uvsq_pkg.sv =====
// Shared types, constants and arithmetic helpers for the UV sphere quad tessellator.
// Used by uvsq_sincos and uv_sphere_quad_tessellator; depends on nothing else.
package uvsq_pkg;

   localparam int MAX_DIVISIONS = 64;
   localparam int MIN_DIVISIONS = 3;
   localparam int CNT_W         = 7;
   localparam int IDX_W         = 6;
   localparam int RADIUS_W      = 22;
   localparam int SCALE_W       = 24;
   localparam int R_W           = RADIUS_W + SCALE_W;
   localparam int R_LO_W        = 23;
   localparam int POS_W         = 32;
   localparam int TEX_W         = 17;
   localparam int Q15_W         = 17;
   localparam int CX_W          = 34;
   localparam int ANG_W         = 32;
   localparam int QUO_W         = 33;
   localparam int PART_W        = R_W - R_LO_W + 1 + Q15_W;
   localparam int OFF_W         = 33;
   localparam int DIV_STEPS     = 8;
   localparam int DIV_STAGES    = 4;
   localparam int CORDIC_STAGES = 8;
   localparam int VERTS         = 6;
   localparam logic signed [CX_W-1:0] CORDIC_INIT = 34'sd652032874;

   // pipeline stage positions
   localparam int ST_ISSUE = 0;
   localparam int ST_DIV0  = 1;
   localparam int ST_SC0   = ST_DIV0 + DIV_STAGES;
   localparam int ST_FOLD  = ST_SC0 + CORDIC_STAGES;
   localparam int ST_MUL   = ST_FOLD + 1;
   localparam int ST_DIR   = ST_MUL + 1;
   localparam int ST_PART  = ST_DIR + 1;
   localparam int ST_OFF   = ST_PART + 1;
   localparam int ST_OUT   = ST_OFF + 1;
   localparam int NSTAGE   = ST_OUT + 1;

   typedef enum logic [2:0] {
      REG_RADIUS       = 3'd0,
      REG_SCALE        = 3'd1,
      REG_CENTER_X     = 3'd2,
      REG_CENTER_Y     = 3'd3,
      REG_CENTER_Z     = 3'd4,
      REG_RING_COUNT   = 3'd5,
      REG_SECTOR_COUNT = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [CNT_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_type;

   typedef struct packed {
      logic signed [CX_W-1:0]  x;
      logic signed [CX_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic             bad;
      logic             last;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
   } meta_type;

   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] r;
      r = n;
      if (n < CNT_W'(MIN_DIVISIONS)) r = CNT_W'(MIN_DIVISIONS);
      if (n > CNT_W'(MAX_DIVISIONS)) r = CNT_W'(MAX_DIVISIONS);
      return r;
   endfunction

   function automatic div_type div_steps(input div_type a, input logic [CNT_W-1:0] d);
      div_type       o;
      logic [CNT_W:0] r2;
      o = a;
      for (int k = 0; k < DIV_STEPS; k++) begin
         r2 = {o.rem, 1'b0};
         if (r2 >= {1'b0, d}) begin
            r2    = r2 - {1'b0, d};
            o.quo = {o.quo[QUO_W-2:0], 1'b1};
         end else begin
            o.quo = {o.quo[QUO_W-2:0], 1'b0};
         end
         o.rem = r2[CNT_W-1:0];
      end
      return o;
   endfunction

   function automatic logic signed [ANG_W-1:0] cordic_atan(input logic [3:0] k);
      logic signed [ANG_W-1:0] a;
      case (k)
         4'd0:    a = 32'sh20000000;
         4'd1:    a = 32'sh12E4051E;
         4'd2:    a = 32'sh09FB385B;
         4'd3:    a = 32'sh051111D4;
         4'd4:    a = 32'sh028B0D43;
         4'd5:    a = 32'sh0145D7E1;
         4'd6:    a = 32'sh00A2F61E;
         4'd7:    a = 32'sh00517C55;
         4'd8:    a = 32'sh0028BE53;
         4'd9:    a = 32'sh00145F2F;
         4'd10:   a = 32'sh000A2F98;
         4'd11:   a = 32'sh000517CC;
         4'd12:   a = 32'sh00028BE6;
         4'd13:   a = 32'sh000145F3;
         4'd14:   a = 32'sh0000A2FA;
         default: a = 32'sh0000517D;
      endcase
      return a;
   endfunction

   function automatic cordic_type cordic_iter(input cordic_type a, input logic [3:0] k);
      cordic_type              o;
      logic signed [CX_W-1:0] dx;
      logic signed [CX_W-1:0] dy;
      dx = a.y >>> k;
      dy = a.x >>> k;
      if (a.z >= 0) begin
         o.x = a.x - dx;
         o.y = a.y + dy;
         o.z = a.z - cordic_atan(k);
      end else begin
         o.x = a.x + dx;
         o.y = a.y - dy;
         o.z = a.z + cordic_atan(k);
      end
      return o;
   endfunction

   // round half up from Q3.30 to Q1.15 and clamp to plus or minus one
   function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CX_W-1:0] v);
      logic signed [CX_W:0]   s;
      logic signed [CX_W-15:0] t;
      logic signed [Q15_W-1:0] r;
      s = {v[CX_W-1], v} + (CX_W+1)'(16384);
      t = s[CX_W:15];
      r = t[Q15_W-1:0];
      if (t > (CX_W-14)'(32768))  r = Q15_W'(32768);
      if (t < -(CX_W-14)'(32768)) r = -Q15_W'(32768);
      return r;
   endfunction

endpackage

// ===== rtl/uvsq_sincos.sv =====
// Pipelined CORDIC sine and cosine of a binary angle, two iterations per stage,
// then quadrant fold and rounding to Q1.15. Depends on uvsq_pkg.
module uvsq_sincos import uvsq_pkg::*; (
   input  logic                    clock,
   input  logic [CORDIC_STAGES:0]  en,
   input  logic [ANG_W-1:0]        ang,
   output logic signed [Q15_W-1:0] sin_q15,
   output logic signed [Q15_W-1:0] cos_q15
);

   cordic_type  stage_ff  [CORDIC_STAGES];
   cordic_type  stage_in  [CORDIC_STAGES];
   cordic_type  stage_src [CORDIC_STAGES];
   logic [1:0]  quad_ff   [CORDIC_STAGES];
   logic [1:0]  quad_src  [CORDIC_STAGES];
   logic signed [Q15_W-1:0] sin_ff, cos_ff;
   logic signed [Q15_W-1:0] xq, yq;

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_head
         assign stage_src[s] = '{x: CORDIC_INIT, y: '0, z: {2'b00, ang[ANG_W-3:0]}};
         assign quad_src[s]  = ang[ANG_W-1:ANG_W-2];
      end else begin : g_tail
         assign stage_src[s] = stage_ff[s-1];
         assign quad_src[s]  = quad_ff[s-1];
      end

      always_comb begin
         cordic_type a;
         a = cordic_iter(stage_src[s], 4'(2*s));
         stage_in[s] = cordic_iter(a, 4'(2*s+1));
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            stage_ff[s] <= stage_in[s];
            quad_ff[s]  <= quad_src[s];
         end
      end
   end

   assign xq = to_q15(stage_ff[CORDIC_STAGES-1].x);
   assign yq = to_q15(stage_ff[CORDIC_STAGES-1].y);

   always_ff @(posedge clock) begin
      if (en[CORDIC_STAGES]) begin
         case (quad_ff[CORDIC_STAGES-1])
            2'd0: begin
               cos_ff <= xq;
               sin_ff <= yq;
            end
            2'd1: begin
               cos_ff <= -yq;
               sin_ff <= xq;
            end
            2'd2: begin
               cos_ff <= -xq;
               sin_ff <= -yq;
            end
            default: begin
               cos_ff <= yq;
               sin_ff <= -xq;
            end
         endcase
      end
   end

   assign sin_q15 = sin_ff;
   assign cos_q15 = cos_ff;

endmodule

// ===== rtl/uv_sphere_quad_tessellator.sv =====
// UV sphere quad tessellator: one quad index in, six vertices of two triangles out.
// One vertex per cycle after the first, while rsp_tready does not stall the output.
// The vertex issue sequencer takes a new quad only as it issues the last vertex (the only one for a bad index).
// The pipeline advances per stage and squeezes out bubbles under output stall.
// Synchronous active-high reset clears control and restores register defaults.
// Depends on uvsq_pkg and uvsq_sincos.
module uv_sphere_quad_tessellator import uvsq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // ring_index[5:0], sector_index[11:6]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
   output logic         rsp_tuser,   // bad_index
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [VERTS-1:0] DI_MASK = 6'b011010;
   localparam logic [VERTS-1:0] DJ_MASK = 6'b110100;

   logic [RADIUS_W-1:0]    radius_ff;
   logic [SCALE_W-1:0]     scale_ff;
   logic signed [POS_W-1:0] center_ff [3];
   logic [CNT_W-1:0]       ring_count_ff, sector_count_ff;
   logic [CNT_W-1:0]       rings, sectors;
   logic [R_W-1:0]         r_ff;
   logic                   cfg_wr;

   logic                   busy_ff, busy_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [IDX_W-1:0]       ri_ff, si_ff;
   logic                   bad_ff;
   logic                   accept, seq_last;

   logic [NSTAGE-1:0]      valid_ff, adv;
   meta_type               meta_ff [NSTAGE];
   logic [CNT_W-1:0]       i0_ff, j0_ff;
   div_type                divt_ff [DIV_STAGES], divp_ff [DIV_STAGES];
   div_type                divt_in [DIV_STAGES], divp_in [DIV_STAGES];
   logic signed [Q15_W-1:0] st, ct, sp, cp;
   logic signed [CX_W-1:0]  pcx_ff, pcz_ff;
   logic signed [Q15_W-1:0] cty_ff;
   logic signed [Q15_W-1:0] dir_ff [3];
   logic signed [PART_W-1:0] ph_ff [3], pl_ff [3];
   logic signed [OFF_W-1:0]  off_ff [3];
   logic signed [POS_W-1:0]  pos_ff [3];

   // configuration
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff       <= RADIUS_W'(65536);
         scale_ff        <= SCALE_W'(65536);
         center_ff[0]    <= '0;
         center_ff[1]    <= '0;
         center_ff[2]    <= '0;
         ring_count_ff   <= CNT_W'(16);
         sector_count_ff <= CNT_W'(32);
      end else if (cfg_wr) begin
         case (reg_index_type'(csr_paddr[4:2]))
            REG_RADIUS:       radius_ff       <= csr_pwdata[RADIUS_W-1:0];
            REG_SCALE:        scale_ff        <= csr_pwdata[SCALE_W-1:0];
            REG_CENTER_X:     center_ff[0]    <= csr_pwdata;
            REG_CENTER_Y:     center_ff[1]    <= csr_pwdata;
            REG_CENTER_Z:     center_ff[2]    <= csr_pwdata;
            REG_RING_COUNT:   ring_count_ff   <= csr_pwdata[CNT_W-1:0];
            REG_SECTOR_COUNT: sector_count_ff <= csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[4:2]))
         REG_RADIUS:       csr_prdata = 32'(radius_ff);
         REG_SCALE:        csr_prdata = 32'(scale_ff);
         REG_CENTER_X:     csr_prdata = center_ff[0];
         REG_CENTER_Y:     csr_prdata = center_ff[1];
         REG_CENTER_Z:     csr_prdata = center_ff[2];
         REG_RING_COUNT:   csr_prdata = 32'(ring_count_ff);
         REG_SECTOR_COUNT: csr_prdata = 32'(sector_count_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign rings   = eff_count(ring_count_ff);
   assign sectors = eff_count(sector_count_ff);

   always_ff @(posedge clock) begin
      r_ff <= R_W'(radius_ff) * R_W'(scale_ff);
   end

   // stage advance chain
   always_comb begin
      adv[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (adv[k]) valid_ff[k] <= (k == 0) ? busy_ff : valid_ff[k-1];
         end
      end
   end

   // vertex issue sequencer
   assign seq_last   = bad_ff || (cnt_ff == 3'(VERTS - 1));
   assign req_tready = !busy_ff || (adv[ST_ISSUE] && seq_last);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff && adv[ST_ISSUE]) begin
         if (seq_last) busy_in = 1'b0;
         else          cnt_in  = cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ri_ff  <= req_tdata[5:0];
         si_ff  <= req_tdata[11:6];
         bad_ff <= ({1'b0, req_tdata[5:0]} >= rings) || ({1'b0, req_tdata[11:6]} >= sectors);
      end
   end

   // issue stage
   always_ff @(posedge clock) begin
      if (adv[ST_ISSUE]) begin
         i0_ff <= {1'b0, ri_ff} + CNT_W'(DI_MASK[cnt_ff]);
         j0_ff <= {1'b0, si_ff} + CNT_W'(DJ_MASK[cnt_ff]);
      end
   end

   // grid fractions by restoring division
   always_comb begin
      div_type t0, p0;
      t0.quo = QUO_W'(i0_ff >= rings);
      t0.rem = (i0_ff >= rings) ? i0_ff - rings : i0_ff;
      p0.quo = QUO_W'(j0_ff >= sectors);
      p0.rem = (j0_ff >= sectors) ? j0_ff - sectors : j0_ff;
      for (int s = 0; s < DIV_STAGES; s++) begin
         divt_in[s] = div_steps((s == 0) ? t0 : divt_ff[s-1], rings);
         divp_in[s] = div_steps((s == 0) ? p0 : divp_ff[s-1], sectors);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (adv[ST_DIV0+s]) begin
            divt_ff[s] <= divt_in[s];
            divp_ff[s] <= divp_in[s];
         end
      end
   end

   // metadata travels with each vertex
   always_ff @(posedge clock) begin
      if (adv[ST_ISSUE]) begin
         meta_ff[ST_ISSUE] <= '{bad: bad_ff, last: seq_last, tex_u: '0, tex_v: '0};
      end
      for (int k = ST_DIV0; k < NSTAGE; k++) begin
         if (adv[k]) begin
            if (k == ST_SC0) begin
               meta_ff[k] <= '{bad:   meta_ff[k-1].bad,
                               last:  meta_ff[k-1].last,
                               tex_u: meta_ff[k-1].bad ? '0 :
                                      divp_ff[DIV_STAGES-1].quo[QUO_W-1:16],
                               tex_v: meta_ff[k-1].bad ? '0 :
                                      divt_ff[DIV_STAGES-1].quo[QUO_W-1:16]};
            end else begin
               meta_ff[k] <= meta_ff[k-1];
            end
         end
      end
   end

   uvsq_sincos u_theta (
      .clock   (clock),
      .en      (adv[ST_FOLD:ST_SC0]),
      .ang     (divt_ff[DIV_STAGES-1].quo[QUO_W-1:1]),
      .sin_q15 (st),
      .cos_q15 (ct)
   );

   uvsq_sincos u_phi (
      .clock   (clock),
      .en      (adv[ST_FOLD:ST_SC0]),
      .ang     (divp_ff[DIV_STAGES-1].quo[ANG_W-1:0]),
      .sin_q15 (sp),
      .cos_q15 (cp)
   );

   // direction and offset
   always_ff @(posedge clock) begin
      if (adv[ST_MUL]) begin
         pcx_ff <= CX_W'(st) * CX_W'(cp);
         pcz_ff <= CX_W'(st) * CX_W'(sp);
         cty_ff <= ct;
      end
      if (adv[ST_DIR]) begin
         dir_ff[0] <= to_q15(pcx_ff);
         dir_ff[1] <= cty_ff;
         dir_ff[2] <= to_q15(pcz_ff);
      end
      for (int a = 0; a < 3; a++) begin
         if (adv[ST_PART]) begin
            ph_ff[a] <= PART_W'($signed({1'b0, r_ff[R_W-1:R_LO_W]})) * PART_W'(dir_ff[a]);
            pl_ff[a] <= PART_W'($signed({1'b0, r_ff[R_LO_W-1:0]})) * PART_W'(dir_ff[a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [63:0]      sum;
      logic signed [OFF_W:0]   p;
      for (int a = 0; a < 3; a++) begin
         if (adv[ST_OFF]) begin
            sum = (64'(ph_ff[a]) <<< R_LO_W) + 64'(pl_ff[a]) + 64'sd1073741824;
            off_ff[a] <= sum[63:31];
         end
         if (adv[ST_OUT]) begin
            p = (OFF_W+1)'(center_ff[a]) + (OFF_W+1)'(off_ff[a]);
            if (meta_ff[ST_OFF].bad)                        pos_ff[a] <= '0;
            else if (p > (OFF_W+1)'(2147483647))           pos_ff[a] <= 32'sh7FFFFFFF;
            else if (p < -(OFF_W+1)'(64'sd2147483648))     pos_ff[a] <= 32'sh80000000;
            else                                            pos_ff[a] <= p[POS_W-1:0];
         end
      end
   end

   assign rsp_tvalid = valid_ff[ST_OUT];
   assign rsp_tdata  = {6'b0, meta_ff[ST_OUT].tex_v, meta_ff[ST_OUT].tex_u,
                        pos_ff[2], pos_ff[1], pos_ff[0]};
   assign rsp_tuser  = meta_ff[ST_OUT].bad;
   assign rsp_tlast  = meta_ff[ST_OUT].last;

   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("bad index item without last");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("bad index item carries data");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> busy_ff && cnt_ff == '0)
      else $error("sequencer did not start on accept");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= 3'(VERTS - 1))
      else $error("vertex counter out of range");

endmodule
